FILE: hw/rtl/signal_processor_dma_and_status_regs_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms shared by the DMA and status register block.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_PROCESSOR_DMA_AND_STATUS_REGS_TOP_ASSERT_SVH
`define SIGNAL_PROCESSOR_DMA_AND_STATUS_REGS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPDSR_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPDSR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/spdsr_pkg.sv
// ----------------------------------------------------------------------------
// spdsr_pkg
// Transfer types, command codes and status bit positions of the DMA block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spdsr_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        xfer_valid;
        logic        xfer_to_dram;
        logic [22:0] dram_word_addr;
        logic [12:0] local_word_addr;
        logic        xfer_last;
        logic        intr_raise;
        logic        intr_clear;
    } result_t;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_TICK,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        REG_MEM_ADDR,
        REG_DRAM_ADDR,
        REG_RD_LEN,
        REG_WR_LEN,
        REG_STATUS,
        REG_FULL,
        REG_BUSY,
        REG_SEMAPHORE
    } reg_sel_t;

    typedef struct packed {
        op_t         op;
        reg_sel_t    reg_sel;
        logic [31:0] data;
    } cmd_t;

    localparam int ST_HALT       = 0;
    localparam int ST_BROKE      = 1;
    localparam int ST_DMA_BUSY   = 2;
    localparam int ST_SSTEP      = 5;
    localparam int ST_INTR_BREAK = 6;
    localparam int ST_SIG0       = 7;
    localparam int NUM_SIGS      = 8;

    localparam int WR_CLR_HALT       = 0;
    localparam int WR_SET_HALT       = 1;
    localparam int WR_CLR_BROKE      = 2;
    localparam int WR_CLR_INTR       = 3;
    localparam int WR_SET_INTR       = 4;
    localparam int WR_CLR_SSTEP      = 5;
    localparam int WR_SET_SSTEP      = 6;
    localparam int WR_CLR_INTR_BREAK = 7;
    localparam int WR_SET_INTR_BREAK = 8;
    localparam int WR_CLR_SIG0       = 9;

    localparam logic [14:0] STATUS_READ_MASK = 15'h7FE3;

endpackage

FILE: hw/rtl/spdsr_front.sv
// ----------------------------------------------------------------------------
// spdsr_front
// Accepts bus items and classifies them into execute commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spdsr_front
(
    input  logic               push,
    output logic               full,
    input  spdsr_pkg::item_t   item,
    output logic               cmd_push,
    input  logic               cmd_full,
    output spdsr_pkg::cmd_t    cmd
);

    always_comb
    begin
        unique case (item.action)
            spdsr_pkg::ACT_READ:  cmd.op = spdsr_pkg::OP_READ;
            spdsr_pkg::ACT_WRITE: cmd.op = spdsr_pkg::OP_WRITE;
            spdsr_pkg::ACT_TICK:  cmd.op = spdsr_pkg::OP_TICK;
            default:              cmd.op = spdsr_pkg::OP_NONE;
        endcase
        cmd.reg_sel = spdsr_pkg::reg_sel_t'(item.reg_index);
        cmd.data    = item.write_data;
    end

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

endmodule

FILE: hw/rtl/spdsr_fifo.sv
// ----------------------------------------------------------------------------
// spdsr_fifo
// Small register queue with independent push and pop sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spdsr_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/spdsr_exec.sv
// ----------------------------------------------------------------------------
// spdsr_exec
// Executes register reads and writes and steps the strided DMA engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signal_processor_dma_and_status_regs_top_assert.svh"

module spdsr_exec
#(
    parameter int BANK_BYTES = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  spdsr_pkg::cmd_t     cmd,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output spdsr_pkg::result_t  res
);

    localparam logic [12:0] BANK13    = 13'(BANK_BYTES);
    localparam logic [13:0] BANK14    = 14'(BANK_BYTES);
    localparam int          MOD_STEPS = 4095 / BANK_BYTES;

    logic [12:0] local_addr_reg,     local_addr_next;
    logic [23:0] dram_addr_reg,      dram_addr_next;
    logic [31:0] read_len_word_reg,  read_len_word_next;
    logic [31:0] write_len_word_reg, write_len_word_next;
    logic [14:0] status_bits_reg,    status_bits_next;
    logic        sem_taken_reg,      sem_taken_next;
    logic        dma_active_reg,     dma_active_next;
    logic        dma_dir_reg,        dma_dir_next;
    logic [12:0] row_length_reg,     row_length_next;
    logic [12:0] row_offset_reg,     row_offset_next;
    logic [7:0]  rows_left_reg,      rows_left_next;
    logic [11:0] row_skip_reg,       row_skip_next;

    logic        go;
    logic [12:0] local_aligned;
    logic [12:0] len_round;
    logic [12:0] bank_offs;
    logic [12:0] start_length;
    logic [12:0] row_off_inc;
    logic [23:0] dram_sum;
    logic [12:0] local_sum;
    logic        row_end;
    logic [31:0] d;

    assign go       = cmd_valid && !res_full;
    assign cmd_pop  = go;
    assign res_push = go;
    assign d        = cmd.data;

    always_comb
    begin
        local_aligned = local_addr_reg & 13'h1FFC;
        len_round     = ({1'b0, d[11:0]} + 13'd8) & 13'h1FF8;
        bank_offs     = {1'b0, local_aligned[11:0]};
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            if (bank_offs >= BANK13)
            begin
                bank_offs = bank_offs - BANK13;
            end
        end
        if (({1'b0, bank_offs} + {1'b0, len_round}) > BANK14)
        begin
            start_length = BANK13 - bank_offs;
        end
        else
        begin
            start_length = len_round;
        end
    end

    assign row_off_inc = row_offset_reg + 13'd4;
    assign row_end     = (row_off_inc >= row_length_reg);
    assign dram_sum    = dram_addr_reg + {11'b0, row_offset_reg};
    assign local_sum   = local_addr_reg + row_offset_reg;

    always_comb
    begin
        local_addr_next     = local_addr_reg;
        dram_addr_next      = dram_addr_reg;
        read_len_word_next  = read_len_word_reg;
        write_len_word_next = write_len_word_reg;
        status_bits_next    = status_bits_reg;
        sem_taken_next      = sem_taken_reg;
        dma_active_next     = dma_active_reg;
        dma_dir_next        = dma_dir_reg;
        row_length_next     = row_length_reg;
        row_offset_next     = row_offset_reg;
        rows_left_next      = rows_left_reg;
        row_skip_next       = row_skip_reg;
        res                 = '0;

        unique case (cmd.op)
            spdsr_pkg::OP_READ:
            begin
                unique case (cmd.reg_sel)
                    spdsr_pkg::REG_MEM_ADDR:  res.read_data = {19'b0, local_addr_reg};
                    spdsr_pkg::REG_DRAM_ADDR: res.read_data = {8'b0, dram_addr_reg};
                    spdsr_pkg::REG_RD_LEN:    res.read_data = read_len_word_reg;
                    spdsr_pkg::REG_WR_LEN:    res.read_data = write_len_word_reg;
                    spdsr_pkg::REG_STATUS:
                    begin
                        res.read_data = {17'b0, status_bits_reg & spdsr_pkg::STATUS_READ_MASK};
                        res.read_data[spdsr_pkg::ST_DMA_BUSY] = dma_active_reg;
                    end
                    spdsr_pkg::REG_FULL:      res.read_data = '0;
                    spdsr_pkg::REG_BUSY:      res.read_data = {31'b0, dma_active_reg};
                    spdsr_pkg::REG_SEMAPHORE:
                    begin
                        res.read_data  = {31'b0, sem_taken_reg};
                        sem_taken_next = 1'b1;
                    end
                    default:                  res.read_data = '0;
                endcase
            end
            spdsr_pkg::OP_WRITE:
            begin
                unique case (cmd.reg_sel) inside
                    spdsr_pkg::REG_MEM_ADDR:
                    begin
                        if (!dma_active_reg)
                        begin
                            local_addr_next = d[12:0];
                        end
                    end
                    spdsr_pkg::REG_DRAM_ADDR:
                    begin
                        if (!dma_active_reg)
                        begin
                            dram_addr_next = d[23:0];
                        end
                    end
                    spdsr_pkg::REG_RD_LEN, spdsr_pkg::REG_WR_LEN:
                    begin
                        if (!dma_active_reg)
                        begin
                            if (cmd.reg_sel == spdsr_pkg::REG_RD_LEN)
                            begin
                                read_len_word_next = d;
                                dma_dir_next       = 1'b0;
                            end
                            else
                            begin
                                write_len_word_next = d;
                                dma_dir_next        = 1'b1;
                            end
                            local_addr_next = local_aligned;
                            dram_addr_next  = dram_addr_reg & 24'hFFFFF8;
                            row_length_next = start_length;
                            row_offset_next = '0;
                            rows_left_next  = d[19:12];
                            row_skip_next   = d[31:20];
                            dma_active_next = 1'b1;
                        end
                    end
                    spdsr_pkg::REG_STATUS:
                    begin
                        if (d[spdsr_pkg::WR_CLR_HALT])
                            status_bits_next[spdsr_pkg::ST_HALT] = 1'b0;
                        else if (d[spdsr_pkg::WR_SET_HALT])
                            status_bits_next[spdsr_pkg::ST_HALT] = 1'b1;
                        if (d[spdsr_pkg::WR_CLR_BROKE])
                            status_bits_next[spdsr_pkg::ST_BROKE] = 1'b0;
                        if (d[spdsr_pkg::WR_CLR_INTR])
                            res.intr_clear = 1'b1;
                        else if (d[spdsr_pkg::WR_SET_INTR])
                            res.intr_raise = 1'b1;
                        if (d[spdsr_pkg::WR_CLR_SSTEP])
                            status_bits_next[spdsr_pkg::ST_SSTEP] = 1'b0;
                        else if (d[spdsr_pkg::WR_SET_SSTEP])
                            status_bits_next[spdsr_pkg::ST_SSTEP] = 1'b1;
                        if (d[spdsr_pkg::WR_CLR_INTR_BREAK])
                            status_bits_next[spdsr_pkg::ST_INTR_BREAK] = 1'b0;
                        else if (d[spdsr_pkg::WR_SET_INTR_BREAK])
                            status_bits_next[spdsr_pkg::ST_INTR_BREAK] = 1'b1;
                        for (int k = 0; k < spdsr_pkg::NUM_SIGS; k++)
                        begin
                            if (d[spdsr_pkg::WR_CLR_SIG0 + 2 * k])
                                status_bits_next[spdsr_pkg::ST_SIG0 + k] = 1'b0;
                            else if (d[spdsr_pkg::WR_CLR_SIG0 + 2 * k + 1])
                                status_bits_next[spdsr_pkg::ST_SIG0 + k] = 1'b1;
                        end
                    end
                    spdsr_pkg::REG_SEMAPHORE:
                    begin
                        if (d == '0)
                        begin
                            sem_taken_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            spdsr_pkg::OP_TICK:
            begin
                if (dma_active_reg)
                begin
                    res.xfer_valid      = 1'b1;
                    res.xfer_to_dram    = dma_dir_reg;
                    res.dram_word_addr  = {dram_sum[22:2], 2'b00};
                    res.local_word_addr = {local_sum[12:2], 2'b00};
                    row_offset_next     = row_off_inc;
                    if (row_end)
                    begin
                        local_addr_next = local_addr_reg + row_length_reg;
                        dram_addr_next  = dram_addr_reg + {11'b0, row_length_reg}
                                        + {12'b0, row_skip_reg};
                        row_offset_next = '0;
                        if (rows_left_reg == '0)
                        begin
                            dma_active_next = 1'b0;
                            res.xfer_last   = 1'b1;
                        end
                        else
                        begin
                            rows_left_next = rows_left_reg - 8'd1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg     <= '0;
            dram_addr_reg      <= '0;
            read_len_word_reg  <= '0;
            write_len_word_reg <= '0;
            status_bits_reg    <= '0;
            sem_taken_reg      <= 1'b0;
            dma_active_reg     <= 1'b0;
            dma_dir_reg        <= 1'b0;
            row_length_reg     <= '0;
            row_offset_reg     <= '0;
            rows_left_reg      <= '0;
            row_skip_reg       <= '0;
        end
        else if (go)
        begin
            local_addr_reg     <= local_addr_next;
            dram_addr_reg      <= dram_addr_next;
            read_len_word_reg  <= read_len_word_next;
            write_len_word_reg <= write_len_word_next;
            status_bits_reg    <= status_bits_next;
            sem_taken_reg      <= sem_taken_next;
            dma_active_reg     <= dma_active_next;
            dma_dir_reg        <= dma_dir_next;
            row_length_reg     <= row_length_next;
            row_offset_reg     <= row_offset_next;
            rows_left_reg      <= rows_left_next;
            row_skip_reg       <= row_skip_next;
        end
    end

    `SPDSR_ASSERT_NOW(a_last_has_xfer, res_push && res.xfer_last, res.xfer_valid,
        "last flag without a transfer")
    `SPDSR_ASSERT_NEXT(a_last_ends_dma, res_push && res.xfer_last, !dma_active_reg,
        "DMA still active after its last transfer")
    `SPDSR_ASSERT_NOW(a_offset_in_row, dma_active_reg,
        (row_length_reg != '0) && (row_offset_reg < row_length_reg),
        "row offset outside the active row")
    `SPDSR_ASSERT_NOW(a_intr_exclusive, res_push && res.intr_raise, !res.intr_clear,
        "interrupt raise and clear in one transfer")

endmodule

FILE: hw/rtl/signal_processor_dma_and_status_regs_top.sv
// ----------------------------------------------------------------------------
// signal_processor_dma_and_status_regs_top
// Strided DMA controller with status register, interrupt pulses and semaphore.
// ----------------------------------------------------------------------------
// Every pushed item (register read, register write or DMA tick) yields exactly
// one result, in order. Sustained rate is one item per clock while the result
// queue has room; an accepted item is registered in the command queue, then
// executed, and its result is registered in the result queue before it can be
// popped. The rate is set by the execute stage, which holds all DMA and register
// state and updates it once per item; queues on both sides of it absorb stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signal_processor_dma_and_status_regs_top
#(
    parameter int BANK_BYTES = 4096,
    parameter int CMD_DEPTH  = 2,
    parameter int RES_DEPTH  = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  spdsr_pkg::item_t    item,
    output logic                empty,
    input  logic                pop,
    output spdsr_pkg::result_t  result
);

    spdsr_pkg::cmd_t    front_cmd;
    spdsr_pkg::cmd_t    exec_cmd;
    spdsr_pkg::result_t exec_res;
    logic               cmd_push;
    logic               cmd_full;
    logic               cmd_empty;
    logic               cmd_pop;
    logic               res_push;
    logic               res_full;

    spdsr_front u_front
    (
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full),
        .cmd      (front_cmd)
    );

    spdsr_fifo
    #(
        .WIDTH ($bits(spdsr_pkg::cmd_t)),
        .DEPTH (CMD_DEPTH)
    )
    u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (exec_cmd),
        .empty     (cmd_empty)
    );

    spdsr_exec
    #(
        .BANK_BYTES (BANK_BYTES)
    )
    u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (exec_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (exec_res)
    );

    spdsr_fifo
    #(
        .WIDTH ($bits(spdsr_pkg::result_t)),
        .DEPTH (RES_DEPTH)
    )
    u_res_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (exec_res),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (result),
        .empty     (empty)
    );

endmodule

FILE: tb/tb_signal_processor_dma_and_status_regs_top.sv
// ----------------------------------------------------------------------------
// tb_signal_processor_dma_and_status_regs_top
// Drives bus reads, bus writes and DMA ticks into the strided DMA and status
// register block through its input queue, and checks every result against a
// cycle-free predictor of the register, status, semaphore and DMA state.
// Directed cases come first, then random DMA runs mixed with noise, with
// random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signal_processor_dma_and_status_regs_top;

    import spdsr_pkg::*;

    localparam int BANK_SIZE    = 4096;
    localparam int RANDOM_ITEMS = 900;
    localparam int BIG_ROOM     = 700;

    class dma_scoreboard;
        result_t     expected_q[$];
        int          faults;
        int          checked;

        logic [12:0] lcl_ptr;
        logic [23:0] ext_ptr;
        logic [31:0] rd_len_reg;
        logic [31:0] wr_len_reg;
        logic [14:0] stat;
        logic        sem_held;
        logic        busy;
        logic        to_ext;
        logic [12:0] row_bytes;
        logic [12:0] row_pos;
        logic [7:0]  rows_rem;
        logic [11:0] stride_gap;

        function new();
            faults     = 0;
            checked    = 0;
            lcl_ptr    = '0;
            ext_ptr    = '0;
            rd_len_reg = '0;
            wr_len_reg = '0;
            stat       = '0;
            sem_held   = 1'b0;
            busy       = 1'b0;
            to_ext     = 1'b0;
            row_bytes  = '0;
            row_pos    = '0;
            rows_rem   = '0;
            stride_gap = '0;
        endfunction

        function void start_dma(logic [31:0] d, logic dir);
            int len;
            int offs;
            len     = int'(d[11:0]) + 1;
            len     = (len + 7) & ~7;
            lcl_ptr = lcl_ptr & 13'h1FFC;
            ext_ptr = ext_ptr & 24'hFFFFF8;
            offs    = int'(lcl_ptr[11:0]) % BANK_SIZE;
            if (offs + len > BANK_SIZE)
            begin
                len = BANK_SIZE - offs;
            end
            row_bytes  = 13'(len);
            row_pos    = '0;
            rows_rem   = d[19:12];
            stride_gap = d[31:20];
            to_ext     = dir;
            busy       = 1'b1;
        endfunction

        function void note_transfer(item_t it);
            result_t     r;
            logic [31:0] d;
            logic [23:0] ext_sum;
            logic [12:0] lcl_sum;
            r = '0;
            d = it.write_data;
            case (it.action)
                ACT_READ:
                begin
                    case (reg_sel_t'(it.reg_index))
                        REG_MEM_ADDR:  r.read_data = 32'(lcl_ptr);
                        REG_DRAM_ADDR: r.read_data = 32'(ext_ptr);
                        REG_RD_LEN:    r.read_data = rd_len_reg;
                        REG_WR_LEN:    r.read_data = wr_len_reg;
                        REG_STATUS:
                        begin
                            r.read_data = 32'(stat & STATUS_READ_MASK);
                            r.read_data[ST_DMA_BUSY] = busy;
                        end
                        REG_FULL:      r.read_data = '0;
                        REG_BUSY:      r.read_data = 32'(busy);
                        default:
                        begin
                            r.read_data = 32'(sem_held);
                            sem_held    = 1'b1;
                        end
                    endcase
                end
                ACT_WRITE:
                begin
                    case (reg_sel_t'(it.reg_index))
                        REG_MEM_ADDR:  if (!busy) lcl_ptr = d[12:0];
                        REG_DRAM_ADDR: if (!busy) ext_ptr = d[23:0];
                        REG_RD_LEN:
                        begin
                            if (!busy)
                            begin
                                rd_len_reg = d;
                                start_dma(d, 1'b0);
                            end
                        end
                        REG_WR_LEN:
                        begin
                            if (!busy)
                            begin
                                wr_len_reg = d;
                                start_dma(d, 1'b1);
                            end
                        end
                        REG_STATUS:
                        begin
                            if (d[WR_CLR_HALT]) stat[ST_HALT] = 1'b0;
                            else if (d[WR_SET_HALT]) stat[ST_HALT] = 1'b1;
                            if (d[WR_CLR_BROKE]) stat[ST_BROKE] = 1'b0;
                            if (d[WR_CLR_INTR]) r.intr_clear = 1'b1;
                            else if (d[WR_SET_INTR]) r.intr_raise = 1'b1;
                            if (d[WR_CLR_SSTEP]) stat[ST_SSTEP] = 1'b0;
                            else if (d[WR_SET_SSTEP]) stat[ST_SSTEP] = 1'b1;
                            if (d[WR_CLR_INTR_BREAK]) stat[ST_INTR_BREAK] = 1'b0;
                            else if (d[WR_SET_INTR_BREAK]) stat[ST_INTR_BREAK] = 1'b1;
                            for (int k = 0; k < NUM_SIGS; k++)
                            begin
                                if (d[WR_CLR_SIG0 + 2 * k]) stat[ST_SIG0 + k] = 1'b0;
                                else if (d[WR_CLR_SIG0 + 2 * k + 1]) stat[ST_SIG0 + k] = 1'b1;
                            end
                        end
                        REG_SEMAPHORE: if (d == '0) sem_held = 1'b0;
                        default: ;
                    endcase
                end
                ACT_TICK:
                begin
                    if (busy)
                    begin
                        ext_sum = ext_ptr + 24'(row_pos);
                        lcl_sum = lcl_ptr + row_pos;
                        r.xfer_valid      = 1'b1;
                        r.xfer_to_dram    = to_ext;
                        r.dram_word_addr  = {ext_sum[22:2], 2'b00};
                        r.local_word_addr = {lcl_sum[12:2], 2'b00};
                        row_pos = row_pos + 13'd4;
                        if (row_pos >= row_bytes)
                        begin
                            lcl_ptr = lcl_ptr + row_bytes;
                            ext_ptr = ext_ptr + 24'(row_bytes) + 24'(stride_gap);
                            row_pos = '0;
                            if (rows_rem == '0)
                            begin
                                busy        = 1'b0;
                                r.xfer_last = 1'b1;
                            end
                            else
                            begin
                                rows_rem = rows_rem - 8'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_transfer(result_t got);
            result_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("transfer %0d: result with nothing expected: %h", checked, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data || got.xfer_valid !== want.xfer_valid ||
                got.xfer_to_dram !== want.xfer_to_dram ||
                got.dram_word_addr !== want.dram_word_addr ||
                got.local_word_addr !== want.local_word_addr ||
                got.xfer_last !== want.xfer_last || got.intr_raise !== want.intr_raise ||
                got.intr_clear !== want.intr_clear)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("transfer %0d mismatch:", checked);
                    $display("    exp rd=%h v=%b dir=%b da=%h la=%h l=%b r=%b c=%b",
                             want.read_data, want.xfer_valid, want.xfer_to_dram,
                             want.dram_word_addr, want.local_word_addr, want.xfer_last,
                             want.intr_raise, want.intr_clear);
                    $display("    got rd=%h v=%b dir=%b da=%h la=%h l=%b r=%b c=%b",
                             got.read_data, got.xfer_valid, got.xfer_to_dram,
                             got.dram_word_addr, got.local_word_addr, got.xfer_last,
                             got.intr_raise, got.intr_clear);
                end
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;

    dma_scoreboard sb = new();
    int            items_sent;
    int            calm_left;

    signal_processor_dma_and_status_regs_top #(
        .BANK_BYTES (BANK_SIZE)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_transfer(result);
        end
    end

    function automatic item_t bus_op(logic [1:0] act, reg_sel_t sel, logic [31:0] d);
        item_t it;
        it.action     = act;
        it.reg_index  = sel;
        it.write_data = d;
        return it;
    endfunction

    function automatic item_t noise_item(logic allow_tick);
        item_t it;
        it.action     = 2'($urandom_range(0, 3));
        it.reg_index  = 3'($urandom_range(0, 7));
        it.write_data = $urandom;
        if (!allow_tick && it.action == ACT_TICK)
            it.action = ACT_READ;
        // keep DMA runs started from noise short
        if (it.action == ACT_WRITE &&
            (it.reg_index == REG_RD_LEN || it.reg_index == REG_WR_LEN))
            it.write_data = it.write_data & ~32'h000F_CFC0;
        return it;
    endfunction

    task automatic sender_gap();
        int n;
        int pick;
        n    = 0;
        pick = $urandom_range(0, 99);
        if (calm_left > 0)
            calm_left--;
        else if (pick < 2)
            calm_left = $urandom_range(20, 80);
        else if (pick < 55)
            n = 0;
        else if (pick < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(4, 30);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(item_t it);
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_transfer(it);
        items_sent++;
        sender_gap();
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic tick();
        send_item(bus_op(ACT_TICK, reg_sel_t'($urandom_range(0, 7)), $urandom));
    endtask

    task automatic run_directed();
        for (int r = 0; r < 8; r++)
            send_item(bus_op(ACT_READ, reg_sel_t'(r), $urandom));
        send_item(bus_op(ACT_READ, REG_SEMAPHORE, '0));
        send_item(bus_op(ACT_WRITE, REG_SEMAPHORE, 32'h0000_0001));
        send_item(bus_op(ACT_WRITE, REG_SEMAPHORE, 32'h0000_0000));
        send_item(bus_op(ACT_WRITE, REG_STATUS, 32'h0155_5552));
        send_item(bus_op(ACT_READ, REG_STATUS, '0));
        send_item(bus_op(ACT_WRITE, REG_STATUS, 32'hFFFF_FFFF));
        send_item(bus_op(ACT_WRITE, REG_STATUS, 32'h5555_5555));
        send_item(bus_op(ACT_WRITE, REG_FULL, 32'hFFFF_FFFF));
        send_item(bus_op(ACT_WRITE, REG_BUSY, 32'hFFFF_FFFF));
        send_item(bus_op(OP_NONE, REG_STATUS, 32'hFFFF_FFFF));
        send_item(bus_op(ACT_WRITE, REG_MEM_ADDR, 32'hFFFF_FFFF));
        send_item(bus_op(ACT_WRITE, REG_DRAM_ADDR, 32'hFFFF_FFFF));
        send_item(bus_op(ACT_WRITE, REG_WR_LEN, 32'hFFF0_0FFF));
        send_item(bus_op(ACT_WRITE, REG_MEM_ADDR, 32'h0000_0000));
        send_item(bus_op(ACT_READ, REG_STATUS, '0));
        tick();
        tick();
        send_item(bus_op(ACT_READ, REG_DRAM_ADDR, '0));
    endtask

    task automatic run_dma(int room);
        logic [31:0] len;
        logic [31:0] maddr;
        int          mode;
        while (sb.busy) tick();
        mode  = (room < BIG_ROOM) ? 99 : $urandom_range(0, 99);
        maddr = $urandom;
        if (mode >= 3 && mode < 6)
        begin
            maddr[11:0] = 12'($urandom_range(12'hE00, 12'hFFF));
            send_item(bus_op(ACT_WRITE, REG_MEM_ADDR, maddr));
        end
        else if ($urandom_range(0, 9) < 7)
            send_item(bus_op(ACT_WRITE, REG_MEM_ADDR, maddr));
        if ($urandom_range(0, 9) < 7)
            send_item(bus_op(ACT_WRITE, REG_DRAM_ADDR, $urandom));
        len = $urandom;
        if (mode < 3)
        begin
            len[11:0]  = 12'($urandom_range(0, 7));
            len[19:12] = 8'hFF;
            len[31:20] = 12'hFFF;
        end
        else if (mode < 6)
        begin
            len[11:0]  = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'($urandom);
            len[19:12] = 8'($urandom_range(0, 1));
        end
        else
        begin
            len[11:0]  = 12'($urandom_range(0, 40));
            len[19:12] = 8'($urandom_range(0, 3));
        end
        send_item(bus_op(ACT_WRITE, ($urandom_range(0, 1) != 0) ? REG_WR_LEN : REG_RD_LEN,
                         len));
        while (sb.busy)
        begin
            if ($urandom_range(0, 99) < 15)
                send_item(noise_item(1'b0));
            else
                tick();
        end
        if ($urandom_range(0, 3) == 0)
            tick();
    endtask

    initial
    begin
        #10ms;
        $display("FAIL signal_processor_dma_and_status_regs_top");
        $finish;
    end

    initial
    begin
        int n;
        pop = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pop <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
            repeat (n) @(posedge clk);
            n = $urandom_range(0, 99);
            if (n < 40)
                n = 0;
            else if (n < 90)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(4, 40);
            if (n > 0)
            begin
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin
        int  random_start;
        bit  drained_mid;
        clk         = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        item        = '0;
        items_sent  = 0;
        calm_left   = 0;
        drained_mid = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        hold_until_drained();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                run_dma(RANDOM_ITEMS - (items_sent - random_start));
            end
            else
            begin
                repeat ($urandom_range(1, 8)) send_item(noise_item(1'b1));
            end
            if (!drained_mid && items_sent - random_start > RANDOM_ITEMS / 2)
            begin
                drained_mid = 1'b1;
                hold_until_drained();
            end
        end

        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.faults == 0 && sb.expected_q.size() == 0)
            $display("PASS signal_processor_dma_and_status_regs_top");
        else
            $display("FAIL signal_processor_dma_and_status_regs_top");
        $finish;
    end

endmodule
